@@ src/icpf_pkg.sv @@
// package for the imu complementary pose filter
// shared types, register indexes and the cordic arctangent table; no dependencies
`timescale 1ns / 1ps
package icpf_pkg;

   // cordic iterations per arctangent, 8 to 24
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = 5;

   // configuration register indexes
   localparam int          CSR_IDX_W         = 8;
   localparam logic [7:0]  CSR_RATE_GAIN     = 8'd0;
   localparam logic [7:0]  CSR_MAGNITUDE_LOW = 8'd1;
   localparam logic [7:0]  CSR_MAGNITUDE_HIGH = 8'd2;
   localparam logic [7:0]  CSR_BLEND_WEIGHT  = 8'd3;

   // register reset values
   localparam logic [15:0] RATE_GAIN_RST      = 16'd182;
   localparam logic [15:0] MAGNITUDE_LOW_RST  = 16'd6554;
   localparam logic [15:0] MAGNITUDE_HIGH_RST = 16'd9830;
   localparam logic [15:0] BLEND_WEIGHT_RST   = 16'd655;

   typedef struct packed {
      logic signed [15:0] accel_raw_x;
      logic signed [15:0] accel_raw_y;
      logic signed [15:0] accel_raw_z;
      logic signed [15:0] gyro_raw_x;
      logic signed [15:0] gyro_raw_y;
      logic signed [15:0] gyro_raw_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] board_accel_x;
      logic signed [15:0] board_accel_y;
      logic signed [15:0] board_accel_z;
      logic signed [15:0] board_rate_x;
      logic signed [15:0] board_rate_y;
      logic signed [15:0] board_rate_z;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
   } rsp_payload_type;

   // sample after the axis remap, as queued between front and back
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
   } sample_type;

   typedef struct packed {
      logic [15:0] rate_gain;
      logic [15:0] magnitude_low;
      logic [15:0] magnitude_high;
      logic [15:0] blend_weight;
   } cfg_type;

   // arctangent of 2^-i, binary angle with pi = 2^31
   function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/imu_complementary_pose_filter.sv @@
// IMU complementary pose filter: one pose result for each accel and gyro sample.
// A sample is remapped to board axes, queued (two deep), then the back end integrates the
// rates into the pose, takes the floor square root of the accel magnitude and, if
// magnitude_low < magnitude < magnitude_high, pulls each angle toward the CORDIC atan2
// tilt angle with blend_weight, using the single shared CORDIC unit that serves the three
// axes in turn. Registers: 0 rate_gain, 1 magnitude_low, 2 magnitude_high, 3 blend_weight;
// writes to other indexes are ignored.
// depends on icpf_pkg, icpf_front, icpf_back
`timescale 1ns / 1ps
module imu_complementary_pose_filter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  icpf_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output icpf_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [icpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]               csr_wdata
);

   icpf_pkg::cfg_type    cfg_ff, cfg_in;
   icpf_pkg::sample_type smp_data;
   logic                 smp_valid, smp_ready;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            icpf_pkg::CSR_RATE_GAIN:      cfg_in.rate_gain      = csr_wdata;
            icpf_pkg::CSR_MAGNITUDE_LOW:  cfg_in.magnitude_low  = csr_wdata;
            icpf_pkg::CSR_MAGNITUDE_HIGH: cfg_in.magnitude_high = csr_wdata;
            icpf_pkg::CSR_BLEND_WEIGHT:   cfg_in.blend_weight   = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_gain      <= icpf_pkg::RATE_GAIN_RST;
         cfg_ff.magnitude_low  <= icpf_pkg::MAGNITUDE_LOW_RST;
         cfg_ff.magnitude_high <= icpf_pkg::MAGNITUDE_HIGH_RST;
         cfg_ff.blend_weight   <= icpf_pkg::BLEND_WEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   icpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .smp_valid (smp_valid),
      .smp_ready (smp_ready),
      .smp_data  (smp_data)
   );

   icpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .smp_valid (smp_valid),
      .smp_ready (smp_ready),
      .smp_data  (smp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/icpf_front.sv @@
// front end: accepts samples, remaps sensor axes to board axes, two-entry queue
// depends on icpf_pkg
`timescale 1ns / 1ps
module icpf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  icpf_pkg::req_payload_type req_data,
   output logic                     smp_valid,
   input  logic                     smp_ready,
   output icpf_pkg::sample_type     smp_data
);

   icpf_pkg::sample_type remap;
   icpf_pkg::sample_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // board x = sensor y, board y = negated sensor x (wraps), z unchanged
   always_comb begin
      remap.accel_x = req_data.accel_raw_y;
      remap.accel_y = -req_data.accel_raw_x;
      remap.accel_z = req_data.accel_raw_z;
      remap.rate_x  = req_data.gyro_raw_y;
      remap.rate_y  = -req_data.gyro_raw_x;
      remap.rate_z  = req_data.gyro_raw_z;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign smp_valid = (count_ff != 2'd0);
   assign pop       = smp_valid && smp_ready;
   assign smp_data  = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= remap;
      end
   end

endmodule

@@ src/icpf_back.sv @@
// back end: integrates rates, computes accel magnitude and cordic tilt, blends pose
// depends on icpf_pkg
`timescale 1ns / 1ps
module icpf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  icpf_pkg::cfg_type         cfg,
   input  logic                      smp_valid,
   output logic                      smp_ready,
   input  icpf_pkg::sample_type      smp_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output icpf_pkg::rsp_payload_type rsp_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INTEG = 4'd1;
   localparam logic [3:0] S_SQRT  = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_CINIT = 4'd4;
   localparam logic [3:0] S_CSTEP = 4'd5;
   localparam logic [3:0] S_CFIN  = 4'd6;
   localparam logic [3:0] S_BLEND = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   localparam logic [4:0] SQRT_STEPS = 5'd17;
   localparam logic [icpf_pkg::STEP_W-1:0] LAST_STEP =
      icpf_pkg::STEP_W'(icpf_pkg::CORDIC_STEPS - 1);

   logic [3:0]                   state_ff, state_in;
   logic [1:0]                   axis_ff, axis_in;
   logic [4:0]                   cnt_ff, cnt_in;
   icpf_pkg::sample_type         smp_ff, smp_in;
   logic signed [15:0]           pose_ff [3];
   logic signed [15:0]           pose_in [3];
   logic [33:0]                  sq_ff, sq_in;
   logic [19:0]                  rem_ff, rem_in;
   logic [16:0]                  root_ff, root_in;
   logic signed [35:0]           cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0]           cz_ff, cz_in;
   logic                         czero_ff, czero_in;
   logic signed [15:0]           ang_ff, ang_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   icpf_pkg::rsp_payload_type    rsp_ff, rsp_in;

   logic signed [15:0] acc_k, rate_k, pose_k, cy_sel, cx_sel;
   logic signed [16:0] rate_x, gain_s, diff_s, w_s;
   logic signed [33:0] prod_int, sum_int, prod_bl;
   logic signed [34:0] sum_bl;
   logic signed [31:0] acc_sq;
   logic signed [15:0] pose_int, pose_bl;
   logic [19:0]        rem_t;
   logic [19:0]        trial;
   logic signed [16:0] nx, ny;
   logic signed [35:0] dx, dy;
   logic signed [33:0] atan_s;
   logic signed [48:0] p_sc;
   logic signed [17:0] q_t;
   logic signed [15:0] q_c;
   logic               mag_ok;

   assign smp_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // per-axis operand selection
   always_comb begin
      case (axis_ff)
         2'd0: begin
            acc_k  = smp_ff.accel_x;
            rate_k = smp_ff.rate_x;
            cy_sel = smp_ff.accel_y;
            cx_sel = smp_ff.accel_z;
         end
         2'd1: begin
            acc_k  = smp_ff.accel_y;
            rate_k = smp_ff.rate_y;
            cy_sel = smp_ff.accel_x;
            cx_sel = smp_ff.accel_z;
         end
         default: begin
            acc_k  = smp_ff.accel_z;
            rate_k = smp_ff.rate_z;
            cy_sel = smp_ff.accel_x;
            cx_sel = smp_ff.accel_y;
         end
      endcase
      pose_k = pose_ff[axis_ff];
   end

   // rate integration, truncated toward zero
   always_comb begin
      rate_x   = {rate_k[15], rate_k};
      gain_s   = {1'b0, cfg.rate_gain};
      prod_int = rate_x * gain_s;
      sum_int  = {{2{pose_k[15]}}, pose_k, 16'd0} + prod_int;
      pose_int = sum_int[31:16] + {15'd0, (sum_int[33] && (|sum_int[15:0]))};
      acc_sq   = acc_k * acc_k;
   end

   // pose blend as pose + (angle - pose) * w, truncated toward zero
   always_comb begin
      diff_s  = {ang_ff[15], ang_ff} - {pose_k[15], pose_k};
      w_s     = {1'b0, cfg.blend_weight};
      prod_bl = diff_s * w_s;
      sum_bl  = {{3{pose_k[15]}}, pose_k, 16'd0} + 35'(prod_bl);
      pose_bl = sum_bl[31:16] + {15'd0, (sum_bl[34] && (|sum_bl[15:0]))};
   end

   // square root digit step, two radicand bits a cycle
   always_comb begin
      rem_t = {rem_ff[17:0], sq_ff[33:32]};
      trial = {1'b0, root_ff, 2'b01};
   end

   // cordic vectoring step and final scale to pi = 32767
   always_comb begin
      nx     = -{cx_sel[15], cx_sel};
      ny     = -{cy_sel[15], cy_sel};
      dx     = cy_ff >>> cnt_ff;
      dy     = cx_ff >>> cnt_ff;
      atan_s = 34'(icpf_pkg::atan_entry(cnt_ff));
      p_sc   = {cz_ff[33:0], 15'd0} - 49'(cz_ff);
      q_t    = p_sc[48:31] + {17'd0, (p_sc[48] && (|p_sc[30:0]))};
      if (q_t > 18'sd32767) begin
         q_c = 16'sd32767;
      end else if (q_t < -18'sd32767) begin
         q_c = -16'sd32767;
      end else begin
         q_c = q_t[15:0];
      end
      mag_ok = ({1'b0, cfg.magnitude_low} < root_ff) && (root_ff < {1'b0, cfg.magnitude_high});
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      smp_in       = smp_ff;
      pose_in      = pose_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      czero_in     = czero_ff;
      ang_in       = ang_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (smp_valid) begin
               smp_in   = smp_data;
               axis_in  = 2'd0;
               sq_in    = 34'd0;
               state_in = S_INTEG;
            end
         end
         S_INTEG: begin
            pose_in[axis_ff] = pose_int;
            sq_in = sq_ff + {2'b00, acc_sq};
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               cnt_in   = 5'd0;
               rem_in   = 20'd0;
               root_in  = 17'd0;
               state_in = S_SQRT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_SQRT: begin
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_ff[15:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_ff[15:0], 1'b0};
            end
            sq_in  = {sq_ff[31:0], 2'b00};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_STEPS - 5'd1) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = mag_ok ? S_CINIT : S_OUT;
         end
         S_CINIT: begin
            czero_in = (cx_sel == 16'sd0) && (cy_sel == 16'sd0);
            if (cx_sel[15]) begin
               cx_in = {{3{nx[16]}}, nx, 16'd0};
               cy_in = {{3{ny[16]}}, ny, 16'd0};
               cz_in = cy_sel[15] ? -34'sd2147483648 : 34'sd2147483648;
            end else begin
               cx_in = {{4{cx_sel[15]}}, cx_sel, 16'd0};
               cy_in = {{4{cy_sel[15]}}, cy_sel, 16'd0};
               cz_in = 34'sd0;
            end
            cnt_in   = 5'd0;
            state_in = S_CSTEP;
         end
         S_CSTEP: begin
            if (!cy_ff[35]) begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + atan_s;
            end else begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - atan_s;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_CFIN;
            end
         end
         S_CFIN: begin
            if (czero_ff) begin
               ang_in = 16'sd0;
            end else if (axis_ff == 2'd1) begin
               ang_in = -q_c;
            end else begin
               ang_in = q_c;
            end
            state_in = S_BLEND;
         end
         S_BLEND: begin
            pose_in[axis_ff] = pose_bl;
            if (axis_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_CINIT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.board_accel_x = smp_ff.accel_x;
               rsp_in.board_accel_y = smp_ff.accel_y;
               rsp_in.board_accel_z = smp_ff.accel_z;
               rsp_in.board_rate_x  = smp_ff.rate_x;
               rsp_in.board_rate_y  = smp_ff.rate_y;
               rsp_in.board_rate_z  = smp_ff.rate_z;
               rsp_in.angle_x       = pose_ff[0];
               rsp_in.angle_y       = pose_ff[1];
               rsp_in.angle_z       = pose_ff[2];
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 2'd0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         pose_ff[0]   <= 16'sd0;
         pose_ff[1]   <= 16'sd0;
         pose_ff[2]   <= 16'sd0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_ff      <= pose_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      smp_ff   <= smp_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      czero_ff <= czero_in;
      ang_ff   <= ang_in;
      rsp_ff   <= rsp_in;
   end

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for imu_complementary_pose_filter: directed table, then random phases
// keeps its own pose predictor and compares every response field; depends on icpf_pkg and the rtl
`timescale 1ns / 1ps
module tb_top;

   // register index that no register answers to
   localparam logic [7:0] CSR_UNUSED_IDX = 8'd4;
   localparam logic [7:0] CSR_TOP_IDX    = 8'hFF;
   localparam int         DRAIN_CYCLES   = 120;

   // arctangent of 2^-i, pi = 2^31
   localparam longint ATAN_LUT [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   typedef struct {
      icpf_pkg::req_payload_type req;
      bit                        typed;
      icpf_pkg::rsp_payload_type rsp;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   icpf_pkg::req_payload_type req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   icpf_pkg::rsp_payload_type rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [7:0]                csr_index;
   logic [15:0]               csr_wdata;

   // predictor state and register copy
   logic signed [15:0]        pose_state [3];
   icpf_pkg::cfg_type         cfg_model;
   icpf_pkg::rsp_payload_type pending_poses [$];
   stim_row_type              stim_table [$];
   int                        error_count;
   int                        send_idle_pct;
   int                        recv_stall_pct;

   imu_complementary_pose_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // cordic atan2, result scaled so pi = 32767
   function automatic logic signed [15:0] tilt_atan2(input longint ys, input longint xs);
      longint vx, vy, acc, dx, dy, q;
      vx = xs;
      vy = ys;
      acc = 0;
      if (vx == 0 && vy == 0) begin
         return 16'sd0;
      end
      if (vx < 0) begin
         acc = (vy >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
         vx = -vx;
         vy = -vy;
      end
      vx = vx * 65536;
      vy = vy * 65536;
      for (int i = 0; i < icpf_pkg::CORDIC_STEPS && i < 24; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx = vx + dx;
            vy = vy - dy;
            acc = acc + ATAN_LUT[i];
         end else begin
            vx = vx - dx;
            vy = vy + dy;
            acc = acc - ATAN_LUT[i];
         end
      end
      q = (acc * 32767) / (64'sd1 <<< 31);
      if (q > 32767) q = 32767;
      if (q < -32767) q = -32767;
      return 16'(q);
   endfunction

   // floor square root, bit by bit
   function automatic longint accel_magnitude(input longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return longint'(root);
   endfunction

   // advance the pose model by one sample and return the expected response
   function automatic icpf_pkg::rsp_payload_type predict_pose(
      input icpf_pkg::req_payload_type d);
      icpf_pkg::rsp_payload_type r;
      logic signed [15:0]        acc [3];
      logic signed [15:0]        rate [3];
      logic signed [15:0]        tilt [3];
      longint                    s, w, mag;
      longint unsigned           sq;
      acc[0] = d.accel_raw_y;
      acc[1] = -d.accel_raw_x;
      acc[2] = d.accel_raw_z;
      rate[0] = d.gyro_raw_y;
      rate[1] = -d.gyro_raw_x;
      rate[2] = d.gyro_raw_z;
      for (int i = 0; i < 3; i++) begin
         s = longint'(pose_state[i]) * 65536 + longint'(rate[i]) * longint'(cfg_model.rate_gain);
         pose_state[i] = 16'(s / 65536);
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq = sq + longint'(acc[i]) * longint'(acc[i]);
      mag = accel_magnitude(sq);
      if (longint'(cfg_model.magnitude_low) < mag && mag < longint'(cfg_model.magnitude_high))
      begin
         w = longint'(cfg_model.blend_weight);
         tilt[0] = tilt_atan2(acc[1], acc[2]);
         tilt[1] = -tilt_atan2(acc[0], acc[2]);
         tilt[2] = tilt_atan2(acc[0], acc[1]);
         for (int i = 0; i < 3; i++) begin
            s = longint'(pose_state[i]) * (65536 - w) + longint'(tilt[i]) * w;
            pose_state[i] = 16'(s / 65536);
         end
      end
      r.board_accel_x = acc[0];
      r.board_accel_y = acc[1];
      r.board_accel_z = acc[2];
      r.board_rate_x  = rate[0];
      r.board_rate_y  = rate[1];
      r.board_rate_z  = rate[2];
      r.angle_x       = pose_state[0];
      r.angle_y       = pose_state[1];
      r.angle_z       = pose_state[2];
      return r;
   endfunction

   function automatic icpf_pkg::req_payload_type make_sample(input int ax, ay, az, gx, gy, gz);
      icpf_pkg::req_payload_type d;
      d.accel_raw_x = 16'(ax);
      d.accel_raw_y = 16'(ay);
      d.accel_raw_z = 16'(az);
      d.gyro_raw_x  = 16'(gx);
      d.gyro_raw_y  = 16'(gy);
      d.gyro_raw_z  = 16'(gz);
      return d;
   endfunction

   task automatic add_row(input icpf_pkg::req_payload_type d);
      stim_row_type row;
      row.req = d;
      row.typed = 1'b0;
      row.rsp = '0;
      stim_table.push_back(row);
   endtask

   task automatic add_typed_row(input icpf_pkg::req_payload_type d,
                                input icpf_pkg::rsp_payload_type r);
      stim_row_type row;
      row.req = d;
      row.typed = 1'b1;
      row.rsp = r;
      stim_table.push_back(row);
   endtask

   // register write transaction, called at a rising edge
   task automatic write_csr(input logic [7:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         icpf_pkg::CSR_RATE_GAIN:      cfg_model.rate_gain      = val;
         icpf_pkg::CSR_MAGNITUDE_LOW:  cfg_model.magnitude_low  = val;
         icpf_pkg::CSR_MAGNITUDE_HIGH: cfg_model.magnitude_high = val;
         icpf_pkg::CSR_BLEND_WEIGHT:   cfg_model.blend_weight   = val;
         default: ;
      endcase
   endtask

   // sample transaction with random idle ahead of it
   task automatic send_sample(input icpf_pkg::req_payload_type d, input bit typed,
                              input icpf_pkg::rsp_payload_type r);
      icpf_pkg::rsp_payload_type predicted;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      predicted = predict_pose(d);
      pending_poses.push_back(typed ? r : predicted);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
      if (e !== a) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name,
                  $signed(e), $signed(a));
         error_count++;
      end
   endtask

   // response checking and receiver stalls
   always @(posedge clock) begin
      icpf_pkg::rsp_payload_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t unexpected response transaction, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            e = pending_poses.pop_front();
            check_field("board_accel_x", e.board_accel_x, rsp_data.board_accel_x);
            check_field("board_accel_y", e.board_accel_y, rsp_data.board_accel_y);
            check_field("board_accel_z", e.board_accel_z, rsp_data.board_accel_z);
            check_field("board_rate_x", e.board_rate_x, rsp_data.board_rate_x);
            check_field("board_rate_y", e.board_rate_y, rsp_data.board_rate_y);
            check_field("board_rate_z", e.board_rate_z, rsp_data.board_rate_z);
            check_field("angle_x", e.angle_x, rsp_data.angle_x);
            check_field("angle_y", e.angle_y, rsp_data.angle_y);
            check_field("angle_z", e.angle_z, rsp_data.angle_z);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // main sequence
   initial begin
      icpf_pkg::rsp_payload_type r;
      icpf_pkg::req_payload_type d;
      int                        lo, hi;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pose_state = '{default: 16'sd0};
      cfg_model.rate_gain      = icpf_pkg::RATE_GAIN_RST;
      cfg_model.magnitude_low  = icpf_pkg::MAGNITUDE_LOW_RST;
      cfg_model.magnitude_high = icpf_pkg::MAGNITUDE_HIGH_RST;
      cfg_model.blend_weight   = icpf_pkg::BLEND_WEIGHT_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings: zero sample, extremes, window edges, tilt quadrants
      r = '0;
      add_typed_row(make_sample(0, 0, 0, 0, 0, 0), r);
      r.board_accel_y = -16'sd32768;
      add_typed_row(make_sample(-32768, 0, 0, 0, 0, 0), r);
      r = '0;
      r.board_rate_y = -16'sd32768;
      r.angle_y = -16'sd91;
      add_typed_row(make_sample(0, 0, 0, -32768, 0, 0), r);
      add_row(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      add_row(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      add_row(make_sample(0, 0, 6554, 100, -100, 50));
      add_row(make_sample(0, 0, 6555, 0, 0, 0));
      add_row(make_sample(0, 0, 9829, 0, 0, 0));
      add_row(make_sample(0, 0, 9830, 0, 0, 0));
      add_row(make_sample(0, 8000, 0, 0, 0, 0));
      add_row(make_sample(-8000, 0, 0, 0, 0, 0));
      add_row(make_sample(3000, 2000, 7000, 500, -700, 900));
      add_row(make_sample(3000, -2000, -7000, 0, 0, 0));
      add_row(make_sample(-3000, 2000, -7000, 0, 0, 0));
      add_row(make_sample(-5000, -5000, -3000, -1, 1, -1));
      add_row(make_sample(4000, 4000, 4000, 32767, -32768, 12345));
      add_row(make_sample(0, -8000, -1, 0, 0, 0));
      add_row(make_sample(1, 0, 8000, 0, 0, 0));
      foreach (stim_table[i])
         send_sample(stim_table[i].req, stim_table[i].typed, stim_table[i].rsp);
      drain();

      // random phases with changing registers and idling
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_csr(icpf_pkg::CSR_RATE_GAIN, 16'hFFFF);
               write_csr(icpf_pkg::CSR_MAGNITUDE_LOW, 16'h0000);
               write_csr(icpf_pkg::CSR_MAGNITUDE_HIGH, 16'hFFFF);
               write_csr(icpf_pkg::CSR_BLEND_WEIGHT, 16'hFFFF);
            end
            1: begin
               write_csr(icpf_pkg::CSR_RATE_GAIN, 16'h0000);
               write_csr(icpf_pkg::CSR_BLEND_WEIGHT, 16'h0000);
               write_csr(CSR_UNUSED_IDX, 16'h1234);
               write_csr(CSR_TOP_IDX, 16'hFFFF);
            end
            2: begin
               write_csr(icpf_pkg::CSR_MAGNITUDE_LOW, 16'hFFFF);
               write_csr(icpf_pkg::CSR_MAGNITUDE_HIGH, 16'h0000);
               write_csr(icpf_pkg::CSR_RATE_GAIN, 16'd182);
            end
            default: begin
               lo = $urandom_range(9000);
               hi = $urandom_range(65535, 9000);
               write_csr(icpf_pkg::CSR_RATE_GAIN, 16'($urandom));
               write_csr(icpf_pkg::CSR_MAGNITUDE_LOW, 16'(lo));
               write_csr(icpf_pkg::CSR_MAGNITUDE_HIGH, 16'(hi));
               write_csr(icpf_pkg::CSR_BLEND_WEIGHT, 16'($urandom));
            end
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         for (int n = 0; n < 88; n++) begin
            if ($urandom_range(99) < 70) begin
               // accel near one g so the tilt correction is exercised
               d = make_sample(int'($urandom_range(14000)) - 7000,
                               int'($urandom_range(14000)) - 7000,
                               int'($urandom_range(14000)) - 7000,
                               $urandom, $urandom, $urandom);
            end else begin
               d = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            send_sample(d, 1'b0, '0);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ imu_complementary_pose_filter.f @@
src/icpf_pkg.sv
src/icpf_front.sv
src/icpf_back.sv
src/imu_complementary_pose_filter.sv
tb/tb_top.sv
